// ----- hdl/h2r_pkg.sv -----
package h2r_pkg;

   // hue geometry in tenths of a degree
   localparam int HUE_TURN   = 3600;
   localparam int HUE_SECTOR = 600;
   localparam int HUE_W      = 12;
   localparam int TDIST_W    = 10;
   localparam int FRAC_IN_W  = 9;

   // floor(x / 75) for x below 28728 as (x * RECIP_MULT) >> RECIP_SHIFT
   localparam int RECIP_SHIFT = 21;
   localparam int RECIP_MULT  = 27963;
   localparam int QUOT_IN_W   = 15;
   localparam int CHAN_W      = 8;

   // six hue sectors, edges belong to the higher one
   typedef enum logic [2:0] {
      SECTOR_RED     = 3'd0,
      SECTOR_YELLOW  = 3'd1,
      SECTOR_GREEN   = 3'd2,
      SECTOR_CYAN    = 3'd3,
      SECTOR_BLUE    = 3'd4,
      SECTOR_MAGENTA = 3'd5
   } h2r_sector_type;

   // register loads of a two-stage section
   typedef struct packed {
      logic load_a;
      logic load_b;
   } h2r_load_type;

endpackage

// ----- hdl/h2r_hue.sv -----
module h2r_hue (
   input  logic                                clock,
   input  logic                                load,
   input  logic [h2r_pkg::HUE_W-1:0]           hue_tenths,
   input  logic [h2r_pkg::FRAC_IN_W-1:0]       sat_clamped,
   input  logic [h2r_pkg::FRAC_IN_W-1:0]       bright_clamped,
   output h2r_pkg::h2r_sector_type             sector_ff,
   output logic [h2r_pkg::TDIST_W-1:0]         tdist_ff,
   output logic [h2r_pkg::FRAC_IN_W-1:0]       sat_ff,
   output logic [h2r_pkg::FRAC_IN_W-1:0]       bright_ff
);

   logic [h2r_pkg::HUE_W-1:0]   hue_wrap;
   logic [h2r_pkg::HUE_W-1:0]   sector_base;
   logic [h2r_pkg::HUE_W-1:0]   rem_full;
   logic [h2r_pkg::TDIST_W-1:0] rem;
   logic                        sector_odd;
   h2r_pkg::h2r_sector_type     sector_in;
   logic [h2r_pkg::TDIST_W-1:0] tdist_in;

   // one wrap is enough for a 12-bit hue
   assign hue_wrap = (hue_tenths >= h2r_pkg::HUE_W'(h2r_pkg::HUE_TURN)) ?
                     hue_tenths - h2r_pkg::HUE_W'(h2r_pkg::HUE_TURN) : hue_tenths;

   // sector search over the sector edges, highest edge first
   always_comb begin
      priority if (hue_wrap >= h2r_pkg::HUE_W'(5 * h2r_pkg::HUE_SECTOR)) begin
         sector_in   = h2r_pkg::SECTOR_MAGENTA;
         sector_base = h2r_pkg::HUE_W'(5 * h2r_pkg::HUE_SECTOR);
      end else if (hue_wrap >= h2r_pkg::HUE_W'(4 * h2r_pkg::HUE_SECTOR)) begin
         sector_in   = h2r_pkg::SECTOR_BLUE;
         sector_base = h2r_pkg::HUE_W'(4 * h2r_pkg::HUE_SECTOR);
      end else if (hue_wrap >= h2r_pkg::HUE_W'(3 * h2r_pkg::HUE_SECTOR)) begin
         sector_in   = h2r_pkg::SECTOR_CYAN;
         sector_base = h2r_pkg::HUE_W'(3 * h2r_pkg::HUE_SECTOR);
      end else if (hue_wrap >= h2r_pkg::HUE_W'(2 * h2r_pkg::HUE_SECTOR)) begin
         sector_in   = h2r_pkg::SECTOR_GREEN;
         sector_base = h2r_pkg::HUE_W'(2 * h2r_pkg::HUE_SECTOR);
      end else if (hue_wrap >= h2r_pkg::HUE_W'(h2r_pkg::HUE_SECTOR)) begin
         sector_in   = h2r_pkg::SECTOR_YELLOW;
         sector_base = h2r_pkg::HUE_W'(h2r_pkg::HUE_SECTOR);
      end else begin
         sector_in   = h2r_pkg::SECTOR_RED;
         sector_base = '0;
      end
   end

   // distance into the sector, mirrored in odd sectors
   assign rem_full   = hue_wrap - sector_base;
   assign rem        = rem_full[h2r_pkg::TDIST_W-1:0];
   assign sector_odd = (sector_in == h2r_pkg::SECTOR_YELLOW) ||
                       (sector_in == h2r_pkg::SECTOR_CYAN) ||
                       (sector_in == h2r_pkg::SECTOR_MAGENTA);
   assign tdist_in   = sector_odd ? h2r_pkg::TDIST_W'(h2r_pkg::HUE_SECTOR) - rem : rem;

   always_ff @(posedge clock) begin
      if (load) begin
         sector_ff <= sector_in;
         tdist_ff  <= tdist_in;
         sat_ff    <= sat_clamped;
         bright_ff <= bright_clamped;
      end
   end

endmodule

// ----- hdl/h2r_mix.sv -----
module h2r_mix #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  h2r_pkg::h2r_load_type                 load,
   input  h2r_pkg::h2r_sector_type               sector,
   input  logic [h2r_pkg::TDIST_W-1:0]           tdist,
   input  logic [h2r_pkg::FRAC_IN_W-1:0]         sat,
   input  logic [h2r_pkg::FRAC_IN_W-1:0]         bright,
   output logic [FRAC_BITS+h2r_pkg::FRAC_IN_W+9:0] num_r_ff,
   output logic [FRAC_BITS+h2r_pkg::FRAC_IN_W+9:0] num_g_ff,
   output logic [FRAC_BITS+h2r_pkg::FRAC_IN_W+9:0] num_b_ff
);

   // weights are at most 600 * ONE, numerators value times weight
   localparam int WW  = FRAC_BITS + 10;
   localparam int NW  = WW + h2r_pkg::FRAC_IN_W;
   localparam int PW  = h2r_pkg::FRAC_IN_W + h2r_pkg::TDIST_W;
   localparam logic [WW-1:0] W_FULL = WW'(h2r_pkg::HUE_SECTOR) << FRAC_BITS;

   logic [h2r_pkg::TDIST_W-1:0] tgap;
   logic [PW-1:0]               prod_x;
   logic [PW-1:0]               prod_all;
   logic [WW-1:0]               w_x;
   logic [WW-1:0]               w_zero;
   logic [WW-1:0]               w_r_in;
   logic [WW-1:0]               w_g_in;
   logic [WW-1:0]               w_b_in;
   logic [WW-1:0]               w_r_ff;
   logic [WW-1:0]               w_g_ff;
   logic [WW-1:0]               w_b_ff;
   logic [h2r_pkg::FRAC_IN_W-1:0] bright_ff;
   logic [NW-1:0]               num_r_in;
   logic [NW-1:0]               num_g_in;
   logic [NW-1:0]               num_b_in;

   // channel weight: full sector weight minus the saturation share removed
   assign tgap     = h2r_pkg::TDIST_W'(h2r_pkg::HUE_SECTOR) - tdist;
   assign prod_x   = PW'(sat) * PW'(tgap);
   assign prod_all = PW'(sat) * PW'(h2r_pkg::HUE_SECTOR);
   // sat never exceeds ONE, so both products fit the weight width
   assign w_x      = W_FULL - WW'(prod_x);
   assign w_zero   = W_FULL - WW'(prod_all);

   // sector routing of chroma, second component and zero
   always_comb begin
      unique case (sector)
         h2r_pkg::SECTOR_RED: begin
            w_r_in = W_FULL; w_g_in = w_x;    w_b_in = w_zero;
         end
         h2r_pkg::SECTOR_YELLOW: begin
            w_r_in = w_x;    w_g_in = W_FULL; w_b_in = w_zero;
         end
         h2r_pkg::SECTOR_GREEN: begin
            w_r_in = w_zero; w_g_in = W_FULL; w_b_in = w_x;
         end
         h2r_pkg::SECTOR_CYAN: begin
            w_r_in = w_zero; w_g_in = w_x;    w_b_in = W_FULL;
         end
         h2r_pkg::SECTOR_BLUE: begin
            w_r_in = w_x;    w_g_in = w_zero; w_b_in = W_FULL;
         end
         default: begin
            w_r_in = W_FULL; w_g_in = w_zero; w_b_in = w_x;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load.load_a) begin
         w_r_ff    <= w_r_in;
         w_g_ff    <= w_g_in;
         w_b_ff    <= w_b_in;
         bright_ff <= bright;
      end
   end

   // value times weight, one multiplier per channel
   assign num_r_in = NW'(bright_ff) * NW'(w_r_ff);
   assign num_g_in = NW'(bright_ff) * NW'(w_g_ff);
   assign num_b_in = NW'(bright_ff) * NW'(w_b_ff);

   always_ff @(posedge clock) begin
      if (load.load_b) begin
         num_r_ff <= num_r_in;
         num_g_ff <= num_g_in;
         num_b_ff <= num_b_in;
      end
   end

endmodule

// ----- hdl/h2r_scale.sv -----
module h2r_scale #(
   parameter int FRAC_BITS = 8
) (
   input  logic                                    clock,
   input  h2r_pkg::h2r_load_type                   load,
   input  logic [FRAC_BITS+h2r_pkg::FRAC_IN_W+9:0] num,
   output logic [h2r_pkg::CHAN_W-1:0]              chan_ff
);

   // channel = floor(255 * num / (600 * ONE^2)) = floor(floor(255 * num / (8 * ONE^2)) / 75)
   localparam int NW = FRAC_BITS + h2r_pkg::FRAC_IN_W + 10;
   localparam int SW = NW + 8;
   localparam int QW = 2 * h2r_pkg::QUOT_IN_W;

   logic [SW-1:0]                    scaled;
   logic [SW-1:0]                    shifted;
   logic [h2r_pkg::QUOT_IN_W-1:0]    quot_in;
   logic [h2r_pkg::QUOT_IN_W-1:0]    quot_ff;
   logic [QW-1:0]                    recip_prod;

   // times 255 by shift and subtract, then drop the power-of-two part
   assign scaled  = {num, 8'd0} - SW'(num);
   assign shifted = scaled >> (2 * FRAC_BITS + 3);
   assign quot_in = shifted[h2r_pkg::QUOT_IN_W-1:0];

   always_ff @(posedge clock) begin
      if (load.load_a) begin
         quot_ff <= quot_in;
      end
   end

   // divide by 75 through the reciprocal, exact since the quotient stays below 19200
   assign recip_prod = QW'(quot_ff) * QW'(h2r_pkg::RECIP_MULT);

   always_ff @(posedge clock) begin
      if (load.load_b) begin
         chan_ff <= recip_prod[h2r_pkg::RECIP_SHIFT +: h2r_pkg::CHAN_W];
      end
   end

endmodule

// ----- hdl/hsv_to_rgb565_converter.sv -----
// HSV to RGB565 converter. One color per transfer on req_: hue in tenths of a degree
// (3600 and up wraps once), saturation and value as fractions where 2^SV_FRAC_BITS is
// 1.0 (larger values clamp to 1.0). Each transfer on rsp_ carries the 8-bit channels,
// floor of fraction times 255, and the RGB565 word built from their top bits. The
// pipeline has five register stages (sector, weight select, value multiply, scale by
// 255, reciprocal divide by 75), and one color is taken every clock while rsp_tready
// stays high. Stages that hold no item let input keep flowing while a result waits at
// the output.
module hsv_to_rgb565_converter #(
   parameter int SV_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // hue_tenths [11:0], saturation [20:12], brightness [29:21], zero [31:30]
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red8 [7:0], green8 [15:8], blue8 [23:16], packed565 [39:24]
   output logic [39:0] rsp_tdata
);

   localparam int STAGES = 5;
   localparam int NW     = SV_FRAC_BITS + h2r_pkg::FRAC_IN_W + 10;
   localparam int ONE    = 1 << SV_FRAC_BITS;

   logic [STAGES-1:0]              valid_ff;
   logic [STAGES-1:0]              valid_in;
   logic [STAGES-1:0]              load;
   logic [h2r_pkg::HUE_W-1:0]      hue_tenths;
   logic [h2r_pkg::FRAC_IN_W-1:0]  saturation;
   logic [h2r_pkg::FRAC_IN_W-1:0]  brightness;
   logic [h2r_pkg::FRAC_IN_W-1:0]  sat_clamped;
   logic [h2r_pkg::FRAC_IN_W-1:0]  bright_clamped;
   h2r_pkg::h2r_sector_type        sector;
   logic [h2r_pkg::TDIST_W-1:0]    tdist;
   logic [h2r_pkg::FRAC_IN_W-1:0]  sat_s1;
   logic [h2r_pkg::FRAC_IN_W-1:0]  bright_s1;
   logic [NW-1:0]                  num_r;
   logic [NW-1:0]                  num_g;
   logic [NW-1:0]                  num_b;
   h2r_pkg::h2r_load_type          mix_load;
   h2r_pkg::h2r_load_type          scale_load;
   logic [h2r_pkg::CHAN_W-1:0]     red8;
   logic [h2r_pkg::CHAN_W-1:0]     green8;
   logic [h2r_pkg::CHAN_W-1:0]     blue8;

   // input unpack and clamp to 1.0
   assign hue_tenths     = req_tdata[11:0];
   assign saturation     = req_tdata[20:12];
   assign brightness     = req_tdata[29:21];
   assign sat_clamped    = (32'(saturation) > ONE) ? h2r_pkg::FRAC_IN_W'(ONE) : saturation;
   assign bright_clamped = (32'(brightness) > ONE) ? h2r_pkg::FRAC_IN_W'(ONE) : brightness;

   // a stage loads when empty or when the next one moves
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = load[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = load[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready        = load[0];
   assign mix_load.load_a   = load[1];
   assign mix_load.load_b   = load[2];
   assign scale_load.load_a = load[3];
   assign scale_load.load_b = load[4];

   h2r_hue u_hue (
      .clock          (clock),
      .load           (load[0]),
      .hue_tenths     (hue_tenths),
      .sat_clamped    (sat_clamped),
      .bright_clamped (bright_clamped),
      .sector_ff      (sector),
      .tdist_ff       (tdist),
      .sat_ff         (sat_s1),
      .bright_ff      (bright_s1)
   );

   h2r_mix #(
      .FRAC_BITS (SV_FRAC_BITS)
   ) u_mix (
      .clock    (clock),
      .load     (mix_load),
      .sector   (sector),
      .tdist    (tdist),
      .sat      (sat_s1),
      .bright   (bright_s1),
      .num_r_ff (num_r),
      .num_g_ff (num_g),
      .num_b_ff (num_b)
   );

   h2r_scale #(
      .FRAC_BITS (SV_FRAC_BITS)
   ) u_scale_r (
      .clock   (clock),
      .load    (scale_load),
      .num     (num_r),
      .chan_ff (red8)
   );

   h2r_scale #(
      .FRAC_BITS (SV_FRAC_BITS)
   ) u_scale_g (
      .clock   (clock),
      .load    (scale_load),
      .num     (num_g),
      .chan_ff (green8)
   );

   h2r_scale #(
      .FRAC_BITS (SV_FRAC_BITS)
   ) u_scale_b (
      .clock   (clock),
      .load    (scale_load),
      .num     (num_b),
      .chan_ff (blue8)
   );

   // result pack
   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = {red8[7:3], green8[7:2], blue8[7:3], blue8, green8, red8};

   // full pipeline behind a stalled output takes no new transfer
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && (&valid_ff[STAGES-2:0])) |-> !req_tready)
      else $error("input taken while pipeline is full and stalled");

   // an accepted transfer occupies the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted transfer lost at first stage");

   // an occupied multiply stage that cannot move keeps its item
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !load[3]) |=> valid_ff[2])
      else $error("stalled item dropped from multiply stage");

   // rgb565 word agrees with the 8-bit channels
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:35] == rsp_tdata[7:3] &&
                      rsp_tdata[34:29] == rsp_tdata[15:10] &&
                      rsp_tdata[28:24] == rsp_tdata[23:19]))
      else $error("packed word does not match channels");

endmodule
